// File: src/belt_pkg.sv
// Shared types, constants and round functions of the belt block cipher.
package belt_pkg;

  localparam int Rounds = 8;
  localparam int RndW = 4;
  localparam int QDepth = 2;

  typedef enum logic [1:0] {
    MODE_ECB_ENC = 2'd0,
    MODE_ECB_DEC = 2'd1,
    MODE_CFB_ENC = 2'd2,
    MODE_CFB_DEC = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_KEY0 = 3'd0,
    REG_KEY1 = 3'd1,
    REG_KEY2 = 3'd2,
    REG_KEY3 = 3'd3,
    REG_SYNC_LO = 3'd4,
    REG_SYNC_HI = 3'd5,
    REG_MODE = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] data_in_3;
    logic [31:0] data_in_2;
    logic [31:0] data_in_1;
    logic [31:0] data_in_0;
    logic [4:0]  valid_bytes;
    logic        restart;
  } in_item_t;

  typedef struct packed {
    logic [31:0] data_out_3;
    logic [31:0] data_out_2;
    logic [31:0] data_out_1;
    logic [31:0] data_out_0;
  } out_item_t;

  // queued job: classified by the front end
  typedef struct packed {
    logic [127:0] blk;
    logic [15:0]  byte_mask;
    logic         restart;
  } job_t;

  function automatic logic [7:0] hsub(input logic [7:0] v);
    logic [7:0] tbl [256];
    tbl = '{
      8'hB1,8'h94,8'hBA,8'hC8,8'h0A,8'h08,8'hF5,8'h3B,8'h36,8'h6D,8'h00,8'h8E,8'h58,8'h4A,8'h5D,8'hE4,
      8'h85,8'h04,8'hFA,8'h9D,8'h1B,8'hB6,8'hC7,8'hAC,8'h25,8'h2E,8'h72,8'hC2,8'h02,8'hFD,8'hCE,8'h0D,
      8'h5B,8'hE3,8'hD6,8'h12,8'h17,8'hB9,8'h61,8'h81,8'hFE,8'h67,8'h86,8'hAD,8'h71,8'h6B,8'h89,8'h0B,
      8'h5C,8'hB0,8'hC0,8'hFF,8'h33,8'hC3,8'h56,8'hB8,8'h35,8'hC4,8'h05,8'hAE,8'hD8,8'hE0,8'h7F,8'h99,
      8'hE1,8'h2B,8'hDC,8'h1A,8'hE2,8'h82,8'h57,8'hEC,8'h70,8'h3F,8'hCC,8'hF0,8'h95,8'hEE,8'h8D,8'hF1,
      8'hC1,8'hAB,8'h76,8'h38,8'h9F,8'hE6,8'h78,8'hCA,8'hF7,8'hC6,8'hF8,8'h60,8'hD5,8'hBB,8'h9C,8'h4F,
      8'hF3,8'h3C,8'h65,8'h7B,8'h63,8'h7C,8'h30,8'h6A,8'hDD,8'h4E,8'hA7,8'h79,8'h9E,8'hB2,8'h3D,8'h31,
      8'h3E,8'h98,8'hB5,8'h6E,8'h27,8'hD3,8'hBC,8'hCF,8'h59,8'h1E,8'h18,8'h1F,8'h4C,8'h5A,8'hB7,8'h93,
      8'hE9,8'hDE,8'hE7,8'h2C,8'h8F,8'h0C,8'h0F,8'hA6,8'h2D,8'hDB,8'h49,8'hF4,8'h6F,8'h73,8'h96,8'h47,
      8'h06,8'h07,8'h53,8'h16,8'hED,8'h24,8'h7A,8'h37,8'h39,8'hCB,8'hA3,8'h83,8'h03,8'hA9,8'h8B,8'hF6,
      8'h92,8'hBD,8'h9B,8'h1C,8'hE5,8'hD1,8'h41,8'h01,8'h54,8'h45,8'hFB,8'hC9,8'h5E,8'h4D,8'h0E,8'hF2,
      8'h68,8'h20,8'h80,8'hAA,8'h22,8'h7D,8'h64,8'h2F,8'h26,8'h87,8'hF9,8'h34,8'h90,8'h40,8'h55,8'h11,
      8'hBE,8'h32,8'h97,8'h13,8'h43,8'hFC,8'h9A,8'h48,8'hA0,8'h2A,8'h88,8'h5F,8'h19,8'h4B,8'h09,8'hA1,
      8'h7E,8'hCD,8'hA4,8'hD0,8'h15,8'h44,8'hAF,8'h8C,8'hA5,8'h84,8'h50,8'hBF,8'h66,8'hD2,8'hE8,8'h8A,
      8'hA2,8'hD7,8'h46,8'h52,8'h42,8'hA8,8'hDF,8'hB3,8'h69,8'h74,8'hC5,8'h51,8'hEB,8'h23,8'h29,8'h21,
      8'hD4,8'hEF,8'hD9,8'hB4,8'h3A,8'h62,8'h28,8'h75,8'h91,8'h14,8'h10,8'hEA,8'h77,8'h6C,8'hDA,8'h1D
    };
    return tbl[v];
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] s, input int r);
    logic [63:0] d;
    d = {s, s} << r;
    return d[63:32];
  endfunction

  function automatic logic [31:0] gfun(input logic [31:0] u, input int r);
    logic [31:0] s;
    s = {hsub(u[31:24]), hsub(u[23:16]), hsub(u[15:8]), hsub(u[7:0])};
    return rotl(s, r);
  endfunction

endpackage

// File: src/belt_front.sv
// Front end: takes input transfers, builds byte masks, feeds the job queue.
module belt_front import belt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  output logic     job_valid,
  input  logic     job_take,
  output job_t     job
);

  job_t                    q [QDepth];
  logic [$clog2(QDepth):0] count;
  logic                    rd_ptr;
  logic                    wr_ptr;
  logic                    push;
  logic                    pop;
  logic [4:0]              nb;
  job_t                    new_job;

  assign in_stall  = (count == ($clog2(QDepth)+1)'(QDepth));
  assign push      = in_valid && !in_stall;
  assign job_valid = (count != '0);
  assign pop       = job_valid && job_take;
  assign job       = q[rd_ptr];

  always_comb begin
    nb = (in_item.valid_bytes > 5'd16) ? 5'd16 : in_item.valid_bytes;
    new_job.blk = {in_item.data_in_3, in_item.data_in_2, in_item.data_in_1,
                   in_item.data_in_0};
    for (int k = 0; k < 16; k++) begin
      new_job.byte_mask[k] = (5'(k) < nb);
    end
    new_job.restart = in_item.restart;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= new_job;
    end
    if (rst) begin
      count  <= '0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + ($clog2(QDepth)+1)'(push) - ($clog2(QDepth)+1)'(pop);
    end
  end

endmodule

// File: src/belt_core.sv
// Back end: one cipher round per cycle, feedback state and output register.
module belt_core import belt_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic [31:0]  key_w [8],
  input  logic [127:0] sync_blk,
  input  mode_t        mode,
  input  logic         job_valid,
  output logic         job_take,
  input  job_t         job,
  output logic         out_valid,
  input  logic         out_stall,
  output out_item_t    out_item
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t        state;
  logic [RndW-1:0] rnd;
  logic [31:0]   a, b, c, d;
  logic [31:0]   a_next, b_next, c_next, d_next;
  logic [127:0]  x_blk;
  logic [15:0]   mask;
  logic [127:0]  fb;
  logic [127:0]  fb_upd;
  logic [127:0]  start_blk;
  logic [127:0]  res;
  logic          dec;
  logic          fin;
  logic [31:0]   k [7];
  logic [31:0]   e;

  assign dec = (mode == MODE_ECB_DEC);
  // last round is applied combinationally while fin is high
  assign fin = (state == ST_RUN) && (rnd == (dec ? RndW'(1) : RndW'(Rounds)));
  // out register free after this cycle
  assign job_take = (state == ST_IDLE) || (fin && (!out_valid || !out_stall));
  assign fb_upd = (mode == MODE_CFB_ENC) ? res : x_blk;

  // a job taken as the previous one finishes chains from that block's feedback
  always_comb begin
    start_blk = job.blk;
    if (mode[1]) begin
      if (job.restart)  start_blk = sync_blk;
      else if (fin)     start_blk = fb_upd;
      else              start_blk = fb;
    end
  end

  always_comb begin
    logic [31:0] ta, tb, tc, td;
    for (int j = 0; j < 7; j++) begin
      k[j] = key_w[3'((7 * (rnd - 1)) + j)];
    end
    ta = a; tb = b; tc = c; td = d;
    if (!dec) begin
      tb ^= gfun(ta + k[0], 5);
      tc ^= gfun(td + k[1], 21);
      ta -= gfun(tb + k[2], 13);
      e = gfun(tb + tc + k[3], 21) ^ 32'(rnd);
      tb += e;
      tc -= e;
      td += gfun(tc + k[4], 13);
      tb ^= gfun(ta + k[5], 21);
      tc ^= gfun(td + k[6], 5);
      a_next = tb; b_next = td; c_next = ta; d_next = tc;
    end else begin
      a_next = tc; b_next = ta; c_next = td; d_next = tb;
      c_next ^= gfun(d_next + k[6], 5);
      b_next ^= gfun(a_next + k[5], 21);
      d_next -= gfun(c_next + k[4], 13);
      e = gfun(b_next + c_next + k[3], 21) ^ 32'(rnd);
      b_next -= e;
      c_next += e;
      a_next += gfun(b_next + k[2], 13);
      c_next ^= gfun(d_next + k[1], 21);
      b_next ^= gfun(a_next + k[0], 5);
    end
  end

  always_comb begin
    logic [127:0] g;
    if (dec) g = {d_next, c_next, b_next, a_next};
    else     g = {c_next, a_next, d_next, b_next};
    res = g;
    if (mode[1]) begin
      for (int i = 0; i < 16; i++) begin
        res[8*i +: 8] = x_blk[8*i +: 8] ^ (mask[i] ? g[8*i +: 8] : 8'h00);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_take) begin
      x_blk <= job.blk;
      mask  <= job.byte_mask;
      if (dec) begin
        a <= start_blk[95:64]; b <= start_blk[31:0];
        c <= start_blk[127:96]; d <= start_blk[63:32];
      end else begin
        a <= start_blk[31:0]; b <= start_blk[63:32];
        c <= start_blk[95:64]; d <= start_blk[127:96];
      end
    end else if (state == ST_RUN && !fin) begin
      a <= a_next; b <= b_next; c <= c_next; d <= d_next;
    end
    if (fin && job_take) begin
      out_item <= res;
    end
    if (rst) begin
      state     <= ST_IDLE;
      rnd       <= '0;
      out_valid <= 1'b0;
      fb        <= '0;
    end else begin
      if (fin && job_take && mode[1]) fb <= fb_upd;
      else if (job_valid && job_take && job.restart) fb <= sync_blk;
      if (fin && job_take) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (job_valid && job_take) begin
        state <= ST_RUN;
        rnd   <= dec ? RndW'(Rounds) : RndW'(1);
      end else if (job_take) begin
        state <= ST_IDLE;
      end else if (state == ST_RUN && !fin) begin
        if (dec) rnd <= (rnd == RndW'(1)) ? RndW'(Rounds) : rnd - RndW'(1);
        else     rnd <= rnd + RndW'(1);
      end
    end
  end

endmodule

// File: src/block_cipher_128_ecb_cfb.sv
// Top level of the belt block cipher with block and feedback modes.
//  channel | signals                              | direction
//  in      | in_valid, in_stall, in_item          | transfer into block
//  out     | out_valid, out_stall, out_item       | transfer out of block
//  cfg     | cfg_we, cfg_index, cfg_data          | register writes
// The round unit works one round a cycle and holds the last round while the output
// is stalled; the next block loads at the edge that registers the last round.
// An input passes through the job queue and the round unit into the output register.
// Reset clears mode, keys, sync and feedback to zero.
// A two-entry job queue sits in front of the round unit; the round unit holds its
// result when the output is stalled and the queue keeps taking input until full.
module block_cipher_128_ecb_cfb import belt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [31:0]  key_w [8];
  logic [127:0] sync_blk;
  mode_t        mode;
  logic         job_valid;
  logic         job_take;
  job_t         job;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) key_w[i] <= '0;
      sync_blk <= '0;
      mode     <= MODE_ECB_ENC;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
          key_w[{cfg_index[1:0], 1'b0}] <= cfg_data[31:0];
          key_w[{cfg_index[1:0], 1'b1}] <= cfg_data[63:32];
        end
        REG_SYNC_LO: sync_blk[63:0]   <= cfg_data;
        REG_SYNC_HI: sync_blk[127:64] <= cfg_data;
        REG_MODE:    mode <= mode_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  belt_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_item,
    .job_valid, .job_take, .job
  );

  belt_core u_core (
    .clk, .rst, .key_w, .sync_blk, .mode,
    .job_valid, .job_take, .job,
    .out_valid, .out_stall, .out_item
  );

endmodule

// File: tb/belt_scoreboard.sv
// Scoreboard for the belt cipher testbench: block predictor and result check.
`timescale 1ns / 100ps
import belt_pkg::*;

class belt_scoreboard;
  logic [31:0] key_words [8];
  logic [31:0] sync_words [4];
  logic [31:0] chain_words [4];
  mode_t       cur_mode;
  out_item_t   pending_blocks [$];
  int          mismatches;

  function new();
    foreach (key_words[k]) key_words[k] = '0;
    foreach (sync_words[k]) sync_words[k] = '0;
    foreach (chain_words[k]) chain_words[k] = '0;
    cur_mode = MODE_ECB_ENC;
    mismatches = 0;
  endfunction

  function void write_reg(reg_idx_t idx, logic [63:0] val);
    case (idx)
      REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
        key_words[2 * int'(idx)] = val[31:0];
        key_words[2 * int'(idx) + 1] = val[63:32];
      end
      REG_SYNC_LO: begin
        sync_words[0] = val[31:0];
        sync_words[1] = val[63:32];
      end
      REG_SYNC_HI: begin
        sync_words[2] = val[31:0];
        sync_words[3] = val[63:32];
      end
      default: cur_mode = mode_t'(val[1:0]);
    endcase
  endfunction

  function logic [7:0] sbox(logic [7:0] v);
    logic [7:0] t [256];
    t = '{
      8'hB1,8'h94,8'hBA,8'hC8,8'h0A,8'h08,8'hF5,8'h3B,8'h36,8'h6D,8'h00,8'h8E,8'h58,8'h4A,8'h5D,8'hE4,
      8'h85,8'h04,8'hFA,8'h9D,8'h1B,8'hB6,8'hC7,8'hAC,8'h25,8'h2E,8'h72,8'hC2,8'h02,8'hFD,8'hCE,8'h0D,
      8'h5B,8'hE3,8'hD6,8'h12,8'h17,8'hB9,8'h61,8'h81,8'hFE,8'h67,8'h86,8'hAD,8'h71,8'h6B,8'h89,8'h0B,
      8'h5C,8'hB0,8'hC0,8'hFF,8'h33,8'hC3,8'h56,8'hB8,8'h35,8'hC4,8'h05,8'hAE,8'hD8,8'hE0,8'h7F,8'h99,
      8'hE1,8'h2B,8'hDC,8'h1A,8'hE2,8'h82,8'h57,8'hEC,8'h70,8'h3F,8'hCC,8'hF0,8'h95,8'hEE,8'h8D,8'hF1,
      8'hC1,8'hAB,8'h76,8'h38,8'h9F,8'hE6,8'h78,8'hCA,8'hF7,8'hC6,8'hF8,8'h60,8'hD5,8'hBB,8'h9C,8'h4F,
      8'hF3,8'h3C,8'h65,8'h7B,8'h63,8'h7C,8'h30,8'h6A,8'hDD,8'h4E,8'hA7,8'h79,8'h9E,8'hB2,8'h3D,8'h31,
      8'h3E,8'h98,8'hB5,8'h6E,8'h27,8'hD3,8'hBC,8'hCF,8'h59,8'h1E,8'h18,8'h1F,8'h4C,8'h5A,8'hB7,8'h93,
      8'hE9,8'hDE,8'hE7,8'h2C,8'h8F,8'h0C,8'h0F,8'hA6,8'h2D,8'hDB,8'h49,8'hF4,8'h6F,8'h73,8'h96,8'h47,
      8'h06,8'h07,8'h53,8'h16,8'hED,8'h24,8'h7A,8'h37,8'h39,8'hCB,8'hA3,8'h83,8'h03,8'hA9,8'h8B,8'hF6,
      8'h92,8'hBD,8'h9B,8'h1C,8'hE5,8'hD1,8'h41,8'h01,8'h54,8'h45,8'hFB,8'hC9,8'h5E,8'h4D,8'h0E,8'hF2,
      8'h68,8'h20,8'h80,8'hAA,8'h22,8'h7D,8'h64,8'h2F,8'h26,8'h87,8'hF9,8'h34,8'h90,8'h40,8'h55,8'h11,
      8'hBE,8'h32,8'h97,8'h13,8'h43,8'hFC,8'h9A,8'h48,8'hA0,8'h2A,8'h88,8'h5F,8'h19,8'h4B,8'h09,8'hA1,
      8'h7E,8'hCD,8'hA4,8'hD0,8'h15,8'h44,8'hAF,8'h8C,8'hA5,8'h84,8'h50,8'hBF,8'h66,8'hD2,8'hE8,8'h8A,
      8'hA2,8'hD7,8'h46,8'h52,8'h42,8'hA8,8'hDF,8'hB3,8'h69,8'h74,8'hC5,8'h51,8'hEB,8'h23,8'h29,8'h21,
      8'hD4,8'hEF,8'hD9,8'hB4,8'h3A,8'h62,8'h28,8'h75,8'h91,8'h14,8'h10,8'hEA,8'h77,8'h6C,8'hDA,8'h1D
    };
    return t[v];
  endfunction

  function logic [31:0] mix(logic [31:0] u, int r);
    logic [31:0] s;
    s = {sbox(u[31:24]), sbox(u[23:16]), sbox(u[15:8]), sbox(u[7:0])};
    return (s << r) | (s >> (32 - r));
  endfunction

  function logic [31:0] rk(int i, int j);
    return key_words[(7 * (i - 1) + j) % 8];
  endfunction

  function void encrypt(input logic [31:0] x [4], output logic [31:0] y [4]);
    logic [31:0] a, b, c, d, e, t;
    a = x[0]; b = x[1]; c = x[2]; d = x[3];
    for (int i = 1; i <= Rounds; i++) begin
      b ^= mix(a + rk(i, 0), 5);
      c ^= mix(d + rk(i, 1), 21);
      a -= mix(b + rk(i, 2), 13);
      e = mix(b + c + rk(i, 3), 21) ^ 32'(i);
      b += e;
      c -= e;
      d += mix(c + rk(i, 4), 13);
      b ^= mix(a + rk(i, 5), 21);
      c ^= mix(d + rk(i, 6), 5);
      t = a; a = b; b = t;
      t = c; c = d; d = t;
      t = b; b = c; c = t;
    end
    y[0] = b; y[1] = d; y[2] = a; y[3] = c;
  endfunction

  function void decrypt(input logic [31:0] x [4], output logic [31:0] y [4]);
    logic [31:0] a, b, c, d, e, t;
    a = x[2]; b = x[0]; c = x[3]; d = x[1];
    for (int i = Rounds; i >= 1; i--) begin
      t = b; b = c; c = t;
      t = c; c = d; d = t;
      t = a; a = b; b = t;
      c ^= mix(d + rk(i, 6), 5);
      b ^= mix(a + rk(i, 5), 21);
      d -= mix(c + rk(i, 4), 13);
      e = mix(b + c + rk(i, 3), 21) ^ 32'(i);
      b -= e;
      c += e;
      a += mix(b + rk(i, 2), 13);
      c ^= mix(d + rk(i, 1), 21);
      b ^= mix(a + rk(i, 0), 5);
    end
    y[0] = a; y[1] = b; y[2] = c; y[3] = d;
  endfunction

  function void note_input(in_item_t it);
    logic [31:0] x [4];
    logic [31:0] y [4];
    logic [31:0] ks [4];
    int nb;
    out_item_t o;
    x[0] = it.data_in_0; x[1] = it.data_in_1;
    x[2] = it.data_in_2; x[3] = it.data_in_3;
    nb = (it.valid_bytes > 16) ? 16 : int'(it.valid_bytes);
    if (it.restart) chain_words = sync_words;
    case (cur_mode)
      MODE_ECB_ENC: encrypt(x, y);
      MODE_ECB_DEC: decrypt(x, y);
      default: begin
        encrypt(chain_words, ks);
        y = x;
        for (int k = 0; k < nb; k++)
          y[k / 4][8 * (k % 4) +: 8] ^= ks[k / 4][8 * (k % 4) +: 8];
        if (cur_mode == MODE_CFB_ENC) chain_words = y;
        else chain_words = x;
      end
    endcase
    o.data_out_0 = y[0]; o.data_out_1 = y[1];
    o.data_out_2 = y[2]; o.data_out_3 = y[3];
    pending_blocks.insert(pending_blocks.size(), o);
  endfunction

  function void check_result(out_item_t got);
    out_item_t exp_blk;
    if (pending_blocks.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result block %h", got);
      return;
    end
    exp_blk = pending_blocks.pop_front();
    if (got.data_out_0 !== exp_blk.data_out_0 || got.data_out_1 !== exp_blk.data_out_1 ||
        got.data_out_2 !== exp_blk.data_out_2 || got.data_out_3 !== exp_blk.data_out_3) begin
      mismatches++;
      if (mismatches <= 10)
        $display("block mismatch: expected %h got %h", exp_blk, got);
    end
  endfunction
endclass

// File: tb/block_cipher_128_ecb_cfb_tb.sv
// Top of the belt cipher testbench: clock, stimulus, sink and run control.
`timescale 1ns / 100ps

module block_cipher_128_ecb_cfb_tb import belt_pkg::*;;
  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  belt_scoreboard sb;
  int  cycle_count = 0;
  bit  hold_sink;
  bit  sink_idle;

  block_cipher_128_ecb_cfb u_top (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("block_cipher_128_ecb_cfb test failed");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // cfg_we is lowered between writes, so each edge carries at most one update
  task automatic write_reg(reg_idx_t idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  // leaves in_valid high; callers drop it before any gap
  task automatic send_block(in_item_t it);
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
  endtask

  task automatic send_with_gap(in_item_t it, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    send_block(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_blocks.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic in_item_t rand_block(bit feedback);
    in_item_t it;
    it.data_in_0 = $urandom;
    it.data_in_1 = $urandom;
    it.data_in_2 = $urandom;
    it.data_in_3 = $urandom;
    if (!feedback || $urandom_range(0, 3) == 0) it.valid_bytes = 5'($urandom_range(0, 31));
    else if ($urandom_range(0, 1)) it.valid_bytes = 5'd16;
    else it.valid_bytes = 5'($urandom_range(1, 16));
    it.restart = ($urandom_range(0, 9) == 0);
    return it;
  endfunction

  task automatic set_keys(bit extreme, bit ones);
    for (int p = 0; p < 6; p++)
      write_reg(reg_idx_t'(p), extreme ? (ones ? '1 : '0) : {$urandom, $urandom});
  endtask

  // sink: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) sb.check_result(out_item);
      out_stall <= hold_sink || (!sink_idle && $urandom_range(0, 99) < 30) ||
                   ($urandom_range(0, 99) < 2);
    end
  end

  initial begin
    in_item_t it;
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_sink = 1'b0;
    sink_idle = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: all-zero and all-one blocks in every mode; reset keys, then all-one keys from mode 2
    for (int m = 0; m < 4; m++) begin
      write_reg(REG_MODE, 64'(m));
      if (m == 2) set_keys(1, 1);
      for (int v = 0; v < 5; v++) begin
        it = '0;
        if (v == 1 || v == 3) begin
          it.data_in_0 = '1; it.data_in_1 = '1; it.data_in_2 = '1; it.data_in_3 = '1;
        end
        it.valid_bytes = (v == 0) ? 5'd0 : (v == 1) ? 5'd16 : (v == 2) ? 5'd31 :
                         (v == 3) ? 5'd1 : 5'd17;
        it.restart = (v == 0 || v == 4);
        send_block(it);
      end
      drain();
    end

    // random phases over modes and keys, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      sink_idle = ph[0];
      set_keys(ph == 1, ph == 1 ? 1'b0 : 1'b1);
      write_reg(REG_MODE, 64'(ph % 4));
      if (ph == 2) begin
        // long hold-off at the sink while the source keeps offering
        fork
          begin
            hold_sink = 1'b1;
            repeat (60) @(posedge clk);
            hold_sink = 1'b0;
          end
          for (int n = 0; n < 12; n++) send_block(rand_block(1));
        join
      end
      for (int n = 0; n < 100; n++) begin
        send_with_gap(rand_block(ph >= 2 && ph != 5), ph != 4);
        if (n == 50) begin
          in_valid <= 1'b0;
          while (sb.pending_blocks.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.pending_blocks.size() == 0)
      $display("block_cipher_128_ecb_cfb test passed");
    else
      $display("block_cipher_128_ecb_cfb test failed");
    $finish;
  end
endmodule
